[src/vfm_pkg.sv]
// Package for the value frequency / mode table unit.
// Holds command codes, controller states and the per-cell control struct.
// No dependencies.
package vfm_pkg;

    localparam int KEY_W     = 32;
    localparam int CMD_W     = 2;
    localparam int OUT_CNT_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_RPT
    } t_state;

    // control that the sequencer hands to every cell
    typedef struct packed {
        logic lookup;     // compare broadcast value against held key
        logic valid;      // cell lies below the fill level
        logic write_new;  // append broadcast value here with count 1
        logic shift;      // take key and count from the next cell
    } t_cell_ctl;

endpackage

[src/vfm_if.sv]
// Valid/ready channel interfaces for the value frequency / mode table unit.
// Depends on vfm_pkg.
interface vfm_in_if;
    import vfm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [KEY_W-1:0]  value;

    modport source (output valid, cmd, value, input ready);
    modport sink   (input valid, cmd, value, output ready);
endinterface

interface vfm_out_if;
    import vfm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [KEY_W-1:0]  entry_key;
    logic [OUT_CNT_W-1:0]     entry_count;
    logic                     is_last;
    logic signed [KEY_W-1:0]  mode_key;
    logic [OUT_CNT_W-1:0]     mode_count;
    logic                     table_empty;
    logic                     overflowed;

    modport source (output valid, entry_key, entry_count, is_last, mode_key,
                    mode_count, table_empty, overflowed, input ready);
    modport sink   (input valid, entry_key, entry_count, is_last, mode_key,
                    mode_count, table_empty, overflowed, output ready);
endinterface

[src/value_frequency_mode_table_unit.sv]
// Top level of the value frequency / mode table unit: sequencer, ring of
// table cells, mode tracker and output register. Uses vfm_pkg, vfm_if, vfm_cell.
//
//  channel  | dir | word                      | fields
//  ---------+-----+---------------------------+----------------------------------------
//  i_req    | in  | one command               | cmd, value
//  o_rsp    | out | one table entry of report | entry_key, entry_count, is_last,
//           |     |                           | mode_key, mode_count, table_empty, overflowed
//
// Add: the command is accepted, then the cells compare and update in parallel
// in the following cycle. Clear and unused codes finish on acceptance. Report:
// the ring of cells rotates once completely, waiting on output stalls, so every
// entry passes cell 0 and lands back in place. i_req.ready is high only when the
// sequencer is idle. The output register lets a finished word wait while the next
// command is taken. i_rst_n is synchronous; it clears the fill level, overflow
// flag, sequencer and output valid; cell contents are not reset.
module value_frequency_mode_table_unit
    import vfm_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vfm_in_if.sink      i_req,
    vfm_out_if.source   o_rsp
);

    localparam int FW = $clog2(DEPTH + 1);          // fill level width
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state                 r_state, n_state;
    logic [FW-1:0]          r_fill, n_fill;
    logic                   r_ovf, n_ovf;
    logic [IW-1:0]          r_idx, n_idx;
    logic [KEY_W-1:0]       r_value;
    logic [KEY_W-1:0]       r_mkey;
    logic [COUNT_WIDTH-1:0] r_mcnt;

    // output register
    logic                   r_ovalid;
    logic [KEY_W-1:0]       r_okey, r_omkey;
    logic [OUT_CNT_W-1:0]   r_ocnt, r_omcnt;
    logic                   r_olast, r_oempty, r_oovf;

    // cell ring
    logic [KEY_W-1:0]       cell_key [DEPTH];
    logic [COUNT_WIDTH-1:0] cell_cnt [DEPTH];
    logic [DEPTH-1:0]       hit_vec;
    logic                   any_hit;
    logic                   lookup, append_en, shift;

    // report datapath
    logic                   can_load, in_range, emit, is_last_e;
    logic [KEY_W-1:0]       cand_key;
    logic [COUNT_WIDTH-1:0] cand_cnt;
    logic [COUNT_WIDTH+OUT_CNT_W-1:0] cnt_ext, mcnt_ext;

    assign lookup    = (r_state == ST_ADD);
    assign any_hit   = |hit_vec;
    assign append_en = lookup && !any_hit && (r_fill != FW'(DEPTH));

    assign can_load  = !r_ovalid || o_rsp.ready;
    assign in_range  = ({{(FW > IW ? FW - IW : 0){1'b0}}, r_idx} < FW'(r_fill));
    assign emit      = (r_state == ST_RPT) && (r_fill != '0) && in_range && can_load;
    // ring moves when the head word goes out, or freely past the filled part
    assign shift     = (r_state == ST_RPT) && (r_fill != '0) && (!in_range || can_load);
    assign is_last_e = ({{(FW > IW ? FW - IW : 0){1'b0}}, r_idx} == r_fill - FW'(1));

    // running mode: strictly greater wins, so earliest entry keeps ties
    always_comb begin
        if (r_idx == '0 || cell_cnt[0] > r_mcnt) begin
            cand_key = cell_key[0];
            cand_cnt = cell_cnt[0];
        end else begin
            cand_key = r_mkey;
            cand_cnt = r_mcnt;
        end
    end

    assign cnt_ext  = {{OUT_CNT_W{1'b0}}, cell_cnt[0]};
    assign mcnt_ext = {{OUT_CNT_W{1'b0}}, cand_cnt};

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            localparam int NXT = (g + 1) % DEPTH;
            t_cell_ctl ctl;

            always_comb begin
                ctl.lookup    = lookup;
                ctl.valid     = (FW'(g) < r_fill);
                ctl.write_new = append_en && (FW'(g) == r_fill);
                ctl.shift     = shift;
            end

            vfm_cell #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (ctl),
                .i_value   (r_value),
                .i_nxt_key (cell_key[NXT]),
                .i_nxt_cnt (cell_cnt[NXT]),
                .o_key     (cell_key[g]),
                .o_cnt     (cell_cnt[g]),
                .o_hit     (hit_vec[g])
            );
        end
    endgenerate

    assign i_req.ready = (r_state == ST_IDLE);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_ovf   = r_ovf;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (i_req.valid) begin
                    case (t_cmd'(i_req.cmd))
                        CMD_ADD:    n_state = ST_ADD;
                        CMD_REPORT: n_state = ST_RPT;
                        CMD_CLEAR: begin
                            n_fill = '0;
                            n_ovf  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD: begin
                if (append_en) begin
                    n_fill = r_fill + FW'(1);
                end else if (!any_hit) begin
                    n_ovf = 1'b1;
                end
                n_state = ST_IDLE;
            end
            ST_RPT: begin
                if (r_fill == '0) begin
                    if (can_load) begin
                        n_state = ST_IDLE;
                    end
                end else if (shift) begin
                    if (r_idx == IW'(DEPTH - 1)) begin
                        n_state = ST_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_value <= i_req.value;
        end
        if (emit) begin
            r_mkey <= cand_key;
            r_mcnt <= cand_cnt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit || (r_state == ST_RPT && r_fill == '0 && can_load)) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RPT && r_fill == '0 && can_load) begin
            r_okey   <= '0;
            r_ocnt   <= '0;
            r_olast  <= 1'b1;
            r_omkey  <= '0;
            r_omcnt  <= '0;
            r_oempty <= 1'b1;
            r_oovf   <= r_ovf;
        end else if (emit) begin
            r_okey   <= cell_key[0];
            r_ocnt   <= cnt_ext[OUT_CNT_W-1:0];
            r_olast  <= is_last_e;
            r_omkey  <= is_last_e ? cand_key : '0;
            r_omcnt  <= is_last_e ? mcnt_ext[OUT_CNT_W-1:0] : '0;
            r_oempty <= 1'b0;
            r_oovf   <= r_ovf;
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.entry_key   = r_okey;
    assign o_rsp.entry_count = r_ocnt;
    assign o_rsp.is_last     = r_olast;
    assign o_rsp.mode_key    = r_omkey;
    assign o_rsp.mode_count  = r_omcnt;
    assign o_rsp.table_empty = r_oempty;
    assign o_rsp.overflowed  = r_oovf;

`ifndef ASSERT_OFF
    // keys in the table are distinct, so a lookup hits at most one cell
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec))
        else $error("more than one cell matched the value");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill level beyond table depth");

    a_add_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |=> (r_state == ST_IDLE))
        else $error("add did not finish in one cycle");

    // a miss on a full table must raise the overflow flag
    a_ovf_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lookup && !any_hit && r_fill == FW'(DEPTH)) |=> r_ovf)
        else $error("dropped value did not set overflow");
`endif

endmodule

[src/vfm_cell.sv]
// One table cell: holds a key and its saturating count.
// Compares against the broadcast value and shifts toward its neighbor. Uses vfm_pkg.
module vfm_cell
    import vfm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic [KEY_W-1:0]        i_value,
    input  logic [KEY_W-1:0]        i_nxt_key,
    input  logic [COUNT_WIDTH-1:0]  i_nxt_cnt,
    output logic [KEY_W-1:0]        o_key,
    output logic [COUNT_WIDTH-1:0]  o_cnt,
    output logic                    o_hit
);

    logic [KEY_W-1:0]       r_key;
    logic [COUNT_WIDTH-1:0] r_cnt;

    assign o_hit = i_ctl.lookup && i_ctl.valid && (r_key == i_value);
    assign o_key = r_key;
    assign o_cnt = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key <= i_nxt_key;
            r_cnt <= i_nxt_cnt;
        end else if (o_hit) begin
            if (r_cnt != {COUNT_WIDTH{1'b1}}) begin
                r_cnt <= r_cnt + COUNT_WIDTH'(1);
            end
        end else if (i_ctl.write_new) begin
            r_key <= i_value;
            r_cnt <= COUNT_WIDTH'(1);
        end
    end

endmodule

[test/tb_value_frequency_mode_table_unit.sv]
// Testbench for value_frequency_mode_table_unit: directed and random commands
// against a table/mode predictor. Depends on vfm_pkg, vfm_if and the unit.
`timescale 1ns / 100ps

module tb_value_frequency_mode_table_unit
    import vfm_pkg::*;
;

    localparam int TBL_DEPTH    = 64;
    localparam int CNT_W        = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam int IDLE_MAX     = 12;
    localparam int RANDOM_ITEMS = 100;
    localparam int HOT_ADDS     = 20;
    // a full report with max stalls still accepts words well within this limit
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_CAP    = 40;

    // one report word as the unit should give it
    typedef struct packed {
        logic signed [KEY_W-1:0] entry_key;
        logic [OUT_CNT_W-1:0]    entry_count;
        logic                    is_last;
        logic signed [KEY_W-1:0] mode_key;
        logic [OUT_CNT_W-1:0]    mode_count;
        logic                    table_empty;
        logic                    overflowed;
    } t_table_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vfm_in_if  req_ch ();
    vfm_out_if rsp_ch ();

    value_frequency_mode_table_unit #(
        .DEPTH       (TBL_DEPTH),
        .COUNT_WIDTH (CNT_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #6 i_clk = ~i_clk;

    // predicted table state
    logic signed [KEY_W-1:0] tbl_keys [TBL_DEPTH];
    logic [CNT_W-1:0]        tbl_counts [TBL_DEPTH];
    int                      tbl_fill;
    logic                    tbl_overflow;

    t_table_word pending_words [$];

    int error_count   = 0;
    int items_sent    = 0;
    int reports_sent  = 0;
    int words_checked = 0;
    int max_fill_seen = 0;
    int overflow_hits = 0;
    int peak_count    = 0;
    int in_gap_max    = IDLE_MAX;
    int out_stall_max = IDLE_MAX;
    int stall_cycles  = 0;

    task automatic report_mismatch(string what, longint got, longint want);
        if (error_count < PRINT_CAP)
            $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // append one expected word at the tail
    function automatic void queue_word(t_table_word w);
        pending_words = {pending_words, w};
    endfunction

    // add: hit bumps the count (saturating), miss appends, full table drops
    function automatic void tally_value(logic signed [KEY_W-1:0] v);
        int slot;
        slot = -1;
        for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_keys[i] == v) begin
                slot = i;
                break;
            end
        end
        if (slot >= 0) begin
            if (tbl_counts[slot] != CNT_MAX)
                tbl_counts[slot]++;
            if (int'(tbl_counts[slot]) > peak_count)
                peak_count = int'(tbl_counts[slot]);
        end else if (tbl_fill < TBL_DEPTH) begin
            tbl_keys[tbl_fill]   = v;
            tbl_counts[tbl_fill] = 1;
            tbl_fill++;
            if (tbl_fill > max_fill_seen)
                max_fill_seen = tbl_fill;
            if (peak_count < 1)
                peak_count = 1;
        end else begin
            tbl_overflow = 1'b1;
            overflow_hits++;
        end
    endfunction

    // report: one word per entry, mode (earliest of the highest) on the last
    function automatic void list_table();
        t_table_word w;
        int          best;
        if (tbl_fill == 0) begin
            w             = '0;
            w.is_last     = 1'b1;
            w.table_empty = 1'b1;
            w.overflowed  = tbl_overflow;
            queue_word(w);
            return;
        end
        best = 0;
        for (int i = 1; i < tbl_fill; i++)
            if (tbl_counts[i] > tbl_counts[best])
                best = i;
        for (int i = 0; i < tbl_fill; i++) begin
            w             = '0;
            w.entry_key   = tbl_keys[i];
            w.entry_count = tbl_counts[i][OUT_CNT_W-1:0];
            w.overflowed  = tbl_overflow;
            if (i == tbl_fill - 1) begin
                w.is_last    = 1'b1;
                w.mode_key   = tbl_keys[best];
                w.mode_count = tbl_counts[best][OUT_CNT_W-1:0];
            end
            queue_word(w);
        end
    endfunction

    // Drives one command word from a falling edge, holds it until taken,
    // then updates the prediction. Returns on a falling edge.
    task automatic send_word(t_cmd c, logic signed [KEY_W-1:0] v);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= c;
        req_ch.value <= v;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        case (c)
            CMD_ADD:    tally_value(v);
            CMD_REPORT: begin
                list_table();
                reports_sent++;
            end
            CMD_CLEAR: begin
                tbl_fill     = 0;
                tbl_overflow = 1'b0;
            end
            default: ;
        endcase
        items_sent++;
        @(negedge i_clk);
    endtask

    // sink side: random stall before each word, ready held until one is taken
    initial begin : drive_ready
        int stall;
        forever begin
            stall = $urandom_range(0, out_stall_max);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_words
        t_table_word want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("word with none expected", rsp_ch.entry_key, 0);
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (rsp_ch.entry_key !== want.entry_key)
                    report_mismatch("entry_key", rsp_ch.entry_key, want.entry_key);
                if (rsp_ch.entry_count !== want.entry_count)
                    report_mismatch("entry_count", rsp_ch.entry_count, want.entry_count);
                if (rsp_ch.is_last !== want.is_last)
                    report_mismatch("is_last", rsp_ch.is_last, want.is_last);
                if (rsp_ch.mode_key !== want.mode_key)
                    report_mismatch("mode_key", rsp_ch.mode_key, want.mode_key);
                if (rsp_ch.mode_count !== want.mode_count)
                    report_mismatch("mode_count", rsp_ch.mode_count, want.mode_count);
                if (rsp_ch.table_empty !== want.table_empty)
                    report_mismatch("table_empty", rsp_ch.table_empty, want.table_empty);
                if (rsp_ch.overflowed !== want.overflowed)
                    report_mismatch("overflowed", rsp_ch.overflowed, want.overflowed);
            end
        end
    end

    // watchdog: too long without a word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d words outstanding",
                     STALL_LIMIT, pending_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // empty table, ignored code, clear of an empty table
    task automatic test_empty_table();
        send_word(CMD_REPORT, 32'sd0);
        send_word(CMD_NONE, -32'sd1);
        send_word(CMD_REPORT, -32'sd1);
        send_word(CMD_CLEAR, 32'sd0);
        send_word(CMD_REPORT, 32'sd0);
    endtask

    // extreme keys, hits, mode ties resolved toward the earliest entry
    task automatic test_extreme_values();
        send_word(CMD_ADD, 32'sh8000_0000);
        send_word(CMD_ADD, 32'sh7FFF_FFFF);
        send_word(CMD_ADD, 32'sd0);
        send_word(CMD_ADD, -32'sd1);
        send_word(CMD_ADD, 32'sh7FFF_FFFF);
        send_word(CMD_ADD, -32'sd1);
        send_word(CMD_ADD, -32'sd1);
        send_word(CMD_REPORT, 32'sd0);
        // 0 catches up with -1; as the earlier entry, 0 must become the mode
        send_word(CMD_ADD, 32'sd0);
        send_word(CMD_ADD, 32'sd0);
        send_word(CMD_REPORT, 32'sh5555_5555);
        send_word(CMD_NONE, 32'sh7FFF_FFFF);
        send_word(CMD_REPORT, 32'shAAAA_AAAA);
        send_word(CMD_CLEAR, -32'sd1);
        send_word(CMD_ADD, 32'sh8000_0000);
        send_word(CMD_REPORT, 32'sd0);
        send_word(CMD_CLEAR, 32'sd0);
    endtask

    // fill all entries, drop one (sticky overflow), hit still counted,
    // clear drops the flag
    task automatic test_table_full();
        logic signed [KEY_W-1:0] base;
        base = $urandom;
        send_word(CMD_CLEAR, 32'sd0);
        for (int i = 0; i < TBL_DEPTH; i++)
            send_word(CMD_ADD, base + i * 7919);
        send_word(CMD_ADD, base + TBL_DEPTH * 7919);
        send_word(CMD_ADD, base + 5 * 7919);
        send_word(CMD_REPORT, $urandom);
        send_word(CMD_ADD, base + 2 * 7919);
        send_word(CMD_REPORT, $urandom);
        send_word(CMD_CLEAR, $urandom);
        send_word(CMD_REPORT, $urandom);
        send_word(CMD_ADD, base);
        send_word(CMD_REPORT, $urandom);
    endtask

    // one value counted many times, then a miss and another hit;
    // runs back to back
    task automatic test_hot_value();
        logic signed [KEY_W-1:0] hot;
        hot           = $urandom;
        in_gap_max    = 0;
        out_stall_max = 0;
        send_word(CMD_CLEAR, 32'sd0);
        for (int i = 0; i < HOT_ADDS; i++)
            send_word(CMD_ADD, hot);
        send_word(CMD_ADD, ~hot);
        send_word(CMD_REPORT, 32'sd0);
        send_word(CMD_ADD, hot);
        send_word(CMD_REPORT, 32'sd0);
        send_word(CMD_CLEAR, 32'sd0);
        in_gap_max    = IDLE_MAX;
        out_stall_max = IDLE_MAX;
    endtask

    // Mostly add bursts over a small value pool ending in a report, so that
    // counts grow and the mode moves; some long bursts of fresh values fill
    // the table. Stray clears, ignored codes and bare reports as noise.
    task automatic test_random_sequences();
        logic signed [KEY_W-1:0] pool [8];
        int start_count;
        int burst;
        bit fresh;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            foreach (pool[i])
                pool[i] = $urandom;
            if ($urandom_range(0, 9) == 0)
                send_word(CMD_CLEAR, $urandom);
            fresh = ($urandom_range(0, 7) == 0);
            burst = fresh ? $urandom_range(55, 75) : $urandom_range(0, 16);
            for (int i = 0; i < burst && items_sent - start_count < RANDOM_ITEMS; i++) begin
                case ($urandom_range(0, 39))
                    0, 1:    send_word(CMD_NONE, $urandom);
                    2:       send_word(CMD_CLEAR, $urandom);
                    3:       send_word(CMD_REPORT, $urandom);
                    default: begin
                        if (fresh || $urandom_range(0, 3) == 0)
                            send_word(CMD_ADD, $urandom);
                        else
                            send_word(CMD_ADD, pool[$urandom_range(0, 7)]);
                    end
                endcase
            end
            send_word(CMD_REPORT, $urandom);
        end
        in_gap_max    = IDLE_MAX;
        out_stall_max = IDLE_MAX;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = CMD_NONE;
        req_ch.value = '0;
        tbl_fill     = 0;
        tbl_overflow = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_extreme_values();
        test_table_full();
        test_hot_value();
        test_random_sequences();

        req_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        // anything arriving now is a stray word
        repeat (2 * TBL_DEPTH + 20) @(posedge i_clk);
        if (pending_words.size() != 0)
            report_mismatch("words never delivered", pending_words.size(), 0);

        $display("Covered %0d commands incl. %0d reports; %0d table words checked.",
                 items_sent, reports_sent, words_checked);
        $display("Peak fill %0d of %0d, %0d dropped adds, highest count %0d.",
                 max_fill_seen, TBL_DEPTH, overflow_hits, peak_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
